[design/dfe_pkg.sv]
`default_nettype none

package dfe_pkg;

    // Sizing of the frame store and of the delimiters.
    localparam int MAX_FRAME     = 64;
    localparam int ADDR_W        = $clog2(MAX_FRAME);
    localparam int PATTERN_BYTES = 8;
    localparam int PAT_IDX_W     = $clog2(PATTERN_BYTES);
    localparam int LEN_W         = 4;
    localparam int IDX_W         = 7;

    // Command queue between matcher and readout.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes.
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_PATTERN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd5;

    localparam logic [5:0]  MAX_LIMIT      = 6'(MAX_FRAME - 2);
    localparam logic [3:0]  RST_START_LEN  = 4'd1;
    localparam logic [3:0]  RST_END_LEN    = 4'd1;
    localparam logic [5:0]  RST_MAX_LEN    = 6'd62;
    localparam logic [31:0] RST_TIMEOUT    = 32'd1000;

    // Store write port driven by the matcher.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    // One readout job: a timeout report or a frame of last_index+1 bytes.
    typedef struct packed {
        logic              timeout;
        logic [ADDR_W-1:0] last_index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] pat_byte(input logic [63:0] pat,
                                            input logic [PAT_IDX_W-1:0] k);
        logic [63:0] sh;
        sh = pat >> {k, 3'b000};
        return sh[7:0];
    endfunction

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return LEN_W'(1);
        end else if (len > LEN_W'(PATTERN_BYTES)) begin
            return LEN_W'(PATTERN_BYTES);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[design/delimited_frame_extractor.sv]
// m_valid rises once a completed frame or timeout has been queued and popped by the
// readout; a frame then gives one byte per cycle while m_ready is high.
// Throughput: one input transaction per cycle, except that input stalls from frame
// completion until the frame's last byte is taken, and while two timeouts wait unread.
// Reset (aresetn low, synchronous) clears the search state, the command queue and the
// readout, and returns all configuration registers to their defaults.
`default_nettype none

module delimited_frame_extractor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port.
    input  wire logic                          cfg_we,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_wdata,
    // Input transactions: bytes, ticks and restarts.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_op,
    input  wire logic [7:0]                    s_data_byte,
    // Result transactions: frame bytes and timeout reports.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [7:0]                         m_frame_byte,
    output logic [5:0]                         m_byte_index,
    output logic                               m_last
);

    // The front end matches delimiters and fills the frame store. Each completed
    // frame or timeout becomes a small command in the queue, and the back end
    // turns that command into a run of result transactions.
    dfe_pkg::store_wr_t     store_wr;
    dfe_pkg::cmd_t          push_cmd;
    dfe_pkg::cmd_t          head;
    dfe_pkg::queue_status_t q_status;
    logic                   push;
    logic                   pop;
    logic                   frame_done;

    dfe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .q_status    (q_status),
        .frame_done  (frame_done),
        .store_wr    (store_wr),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    dfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // The back end owns the frame store; frame_done tells the front end that
    // the store may be written again.
    dfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .store_wr     (store_wr),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .frame_done   (frame_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_frame_byte (m_frame_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

[design/dfe_front.sv]
`default_nettype none

module dfe_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                 cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic [7:0]                  s_data_byte,
    input  wire dfe_pkg::queue_status_t      q_status,
    input  wire logic                        frame_done,
    output dfe_pkg::store_wr_t               store_wr,
    output logic                             push,
    output dfe_pkg::cmd_t                    push_cmd
);

    logic [63:0] start_pat_reg;
    logic [3:0]  start_len_reg;
    logic [63:0] end_pat_reg;
    logic [3:0]  end_len_reg;
    logic [5:0]  max_len_reg;
    logic [31:0] timeout_reg;

    logic [dfe_pkg::IDX_W-1:0] wi_reg, wi_next, wi_inc;
    logic                      start_seen_reg, start_seen_next;
    logic [3:0]                emc_reg, emc_next, emc_inc;
    logic [31:0]               tick_reg, tick_next, tick_inc;
    logic                      fin_reg, fin_next;
    logic                      busy_reg, busy_next;

    logic [3:0] slen, elen;
    logic [5:0] limit;
    logic       completed;

    assign slen  = dfe_pkg::eff_len(start_len_reg);
    assign elen  = dfe_pkg::eff_len(end_len_reg);
    assign limit = (max_len_reg > dfe_pkg::MAX_LIMIT) ? dfe_pkg::MAX_LIMIT : max_len_reg;

    // A pending frame readout holds off input so the store is not overwritten.
    assign s_ready = !q_status.full && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pat_reg <= '0;
            start_len_reg <= dfe_pkg::RST_START_LEN;
            end_pat_reg   <= '0;
            end_len_reg   <= dfe_pkg::RST_END_LEN;
            max_len_reg   <= dfe_pkg::RST_MAX_LEN;
            timeout_reg   <= dfe_pkg::RST_TIMEOUT;
        end else if (cfg_we) begin
            case (cfg_index)
                dfe_pkg::REG_START_PATTERN: start_pat_reg <= cfg_wdata;
                dfe_pkg::REG_START_LENGTH:  start_len_reg <= cfg_wdata[3:0];
                dfe_pkg::REG_END_PATTERN:   end_pat_reg   <= cfg_wdata;
                dfe_pkg::REG_END_LENGTH:    end_len_reg   <= cfg_wdata[3:0];
                dfe_pkg::REG_MAX_LENGTH:    max_len_reg   <= cfg_wdata[5:0];
                dfe_pkg::REG_TIMEOUT_TICKS: timeout_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        wi_next         = wi_reg;
        start_seen_next = start_seen_reg;
        emc_next        = emc_reg;
        tick_next       = tick_reg;
        fin_next        = fin_reg;
        busy_next       = busy_reg && !frame_done;
        store_wr        = '0;
        push            = 1'b0;
        push_cmd        = '0;
        completed       = 1'b0;
        wi_inc          = wi_reg + dfe_pkg::IDX_W'(1);
        emc_inc         = emc_reg + 4'd1;
        tick_inc        = (tick_reg != '1) ? tick_reg + 32'd1 : tick_reg;

        if (s_valid && s_ready) begin
            case (s_op)
                dfe_pkg::OP_RESTART: begin
                    wi_next         = '0;
                    start_seen_next = 1'b0;
                    emc_next        = '0;
                    tick_next       = '0;
                    fin_next        = 1'b0;
                end
                dfe_pkg::OP_TICK: begin
                    if (!fin_reg) begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg) begin
                            fin_next         = 1'b1;
                            push             = 1'b1;
                            push_cmd.timeout = 1'b1;
                        end
                    end
                end
                dfe_pkg::OP_BYTE: begin
                    if (!fin_reg) begin
                        if (!start_seen_reg) begin
                            if (s_data_byte == dfe_pkg::pat_byte(start_pat_reg,
                                    wi_reg[dfe_pkg::PAT_IDX_W-1:0])) begin
                                store_wr.en   = 1'b1;
                                store_wr.addr = wi_reg[dfe_pkg::ADDR_W-1:0];
                                store_wr.data = s_data_byte;
                                if (wi_inc >= dfe_pkg::IDX_W'(slen)) begin
                                    start_seen_next = 1'b1;
                                end else begin
                                    wi_next = wi_inc;
                                end
                            end else if (s_data_byte == dfe_pkg::pat_byte(start_pat_reg,
                                    '0)) begin
                                store_wr.en   = 1'b1;
                                store_wr.addr = '0;
                                store_wr.data = s_data_byte;
                                wi_next       = dfe_pkg::IDX_W'(1);
                            end else begin
                                wi_next = '0;
                            end
                        end else begin
                            wi_next       = wi_inc;
                            store_wr.en   = 1'b1;
                            store_wr.addr = wi_inc[dfe_pkg::ADDR_W-1:0];
                            store_wr.data = s_data_byte;
                            if (s_data_byte == dfe_pkg::pat_byte(end_pat_reg,
                                    emc_reg[dfe_pkg::PAT_IDX_W-1:0])) begin
                                emc_next = emc_inc;
                                if (emc_inc >= elen) begin
                                    completed           = 1'b1;
                                    fin_next            = 1'b1;
                                    busy_next           = 1'b1;
                                    push                = 1'b1;
                                    push_cmd.last_index = wi_inc[dfe_pkg::ADDR_W-1:0];
                                end
                            end else if (s_data_byte == dfe_pkg::pat_byte(end_pat_reg,
                                    '0)) begin
                                emc_next = 4'd1;
                            end else begin
                                emc_next = '0;
                            end
                        end
                        // The completing byte is exempt from the length limit.
                        if (!completed && wi_next > dfe_pkg::IDX_W'(limit)) begin
                            wi_next         = '0;
                            start_seen_next = 1'b0;
                            emc_next        = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg         <= '0;
            start_seen_reg <= 1'b0;
            emc_reg        <= '0;
            tick_reg       <= '0;
            fin_reg        <= 1'b0;
            busy_reg       <= 1'b0;
        end else begin
            wi_reg         <= wi_next;
            start_seen_reg <= start_seen_next;
            emc_reg        <= emc_next;
            tick_reg       <= tick_next;
            fin_reg        <= fin_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

`default_nettype wire

[design/dfe_queue.sv]
`default_nettype none

module dfe_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire dfe_pkg::cmd_t          push_cmd,
    input  wire logic                   pop,
    output dfe_pkg::cmd_t               head,
    output dfe_pkg::queue_status_t      status
);

    dfe_pkg::cmd_t entries [dfe_pkg::QUEUE_DEPTH];

    logic [dfe_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dfe_pkg::QCNT_W-1:0] count_reg;
    logic                       do_push, do_pop;

    assign status.full  = (count_reg == dfe_pkg::QCNT_W'(dfe_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == dfe_pkg::QPTR_W'(dfe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + dfe_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == dfe_pkg::QPTR_W'(dfe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + dfe_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + dfe_pkg::QCNT_W'(1);
                2'b01:   count_reg <= count_reg - dfe_pkg::QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/dfe_back.sv]
`default_nettype none

module dfe_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dfe_pkg::store_wr_t     store_wr,
    input  wire dfe_pkg::cmd_t          head,
    input  wire dfe_pkg::queue_status_t q_status,
    output logic                        pop,
    output logic                        frame_done,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_kind,
    output logic [7:0]                  m_frame_byte,
    output logic [5:0]                  m_byte_index,
    output logic                        m_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] store [dfe_pkg::MAX_FRAME];
    logic [7:0] rd_data_reg;
    logic       rd_en;
    logic [dfe_pkg::ADDR_W-1:0] rd_addr;

    logic                       kind_reg, kind_next;
    logic [dfe_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [dfe_pkg::ADDR_W-1:0] last_idx_reg, last_idx_next;

    always_ff @(posedge aclk) begin
        if (store_wr.en) begin
            store[store_wr.addr] <= store_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= store[rd_addr];
        end
    end

    assign m_valid      = (state_reg == ST_SHOW);
    assign m_kind       = kind_reg;
    assign m_frame_byte = kind_reg ? 8'd0 : rd_data_reg;
    assign m_byte_index = kind_reg ? 6'd0 : 6'(idx_reg);
    assign m_last       = kind_reg || (idx_reg == last_idx_reg);
    assign frame_done   = m_valid && m_ready && m_last && !kind_reg;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop           = 1'b1;
                    kind_next     = head.timeout;
                    idx_next      = '0;
                    last_idx_next = head.timeout ? '0 : head.last_index;
                    rd_en         = !head.timeout;
                    state_next    = ST_SHOW;
                end
            end
            ST_SHOW: begin
                if (m_ready) begin
                    if (m_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next byte so it shows right after this one.
                        idx_next = idx_reg + dfe_pkg::ADDR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + dfe_pkg::ADDR_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
    end

endmodule

`default_nettype wire

[design/dfe_checker.sv]
`default_nettype none

module dfe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_kind,
    input wire logic [7:0] m_frame_byte,
    input wire logic [5:0] m_byte_index,
    input wire logic       m_last
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_frame_byte)
            && $stable(m_byte_index) && $stable(m_last))
        else $error("stalled result changed");

    // A timeout report is a single final transaction with zero payload.
    a_timeout_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_last && m_frame_byte == 8'd0 && m_byte_index == 6'd0)
        else $error("malformed timeout result");

    // Frame bytes follow each other without gaps and with rising index.
    a_frame_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_kind && !m_last |=>
            m_valid && !m_kind && m_byte_index == 6'($past(m_byte_index) + 6'd1))
        else $error("frame run broken");

    // Input is held off while a frame is being read out.
    a_stall_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind && !m_last |-> !s_ready)
        else $error("input accepted during frame readout");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind delimited_frame_extractor dfe_checker u_dfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_frame_byte (m_frame_byte),
    .m_byte_index (m_byte_index),
    .m_last       (m_last)
);

`default_nettype wire

[tb/tb_delimited_frame_extractor.sv]
`default_nettype none

// Self-checking bench for the delimited frame extractor. A driver and a monitor are
// clocked always blocks. The driver takes input transactions from a queue that the
// initial block fills, and every accepted transaction goes through a behavioral copy of
// the extractor. That copy appends the frame bytes or the timeout report it causes to a
// queue of results still due, and the monitor checks each accepted result against the
// oldest entry of that queue.
module tb_delimited_frame_extractor;

    timeunit 1ns;
    timeprecision 1ps;

    import dfe_pkg::*;

    // The package names three operations; the fourth encoding has to be ignored.
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_TIMEOUT = 1'b1;

    // Longest stretch without any accepted transaction before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] fbyte;
        logic [5:0] pos;
        logic       is_last;
    } frame_out_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_wdata = '0;

    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_op        = OP_BYTE;
    logic [7:0] s_data_byte = 8'h00;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_frame_byte;
    logic [5:0] m_byte_index;
    logic       m_last;

    delimited_frame_extractor u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_frame_byte (m_frame_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Transactions waiting to be offered, and results that the block still owes.
    rx_item_t   rx_stream[$];
    frame_out_t out_due[$];

    int err_count       = 0;
    int items_taken     = 0;
    int results_seen    = 0;
    int frames_seen     = 0;
    int timeouts_seen   = 0;
    int settings_loaded = 0;
    int stim_count      = 0;

    // Behavioral copy of the registers, starting from their reset values.
    logic [63:0] cfg_sp  = 64'd0;
    logic [3:0]  cfg_sl  = RST_START_LEN;
    logic [63:0] cfg_ep  = 64'd0;
    logic [3:0]  cfg_el  = RST_END_LEN;
    logic [5:0]  cfg_ml  = RST_MAX_LEN;
    logic [31:0] cfg_tmo = RST_TIMEOUT;

    // Behavioral copy of the search state. The store starts at zero, although every
    // entry that gets emitted is written earlier in the same frame.
    logic [7:0]  store_img [MAX_FRAME];
    int unsigned fill_idx   = 0;
    bit          hdr_found  = 1'b0;
    int unsigned tail_hits  = 0;
    logic [31:0] tick_acc   = 32'd0;
    bit          frame_done = 1'b0;

    initial begin
        foreach (store_img[i]) store_img[i] = 8'h00;
    end

    // Byte k of a delimiter, the first byte sitting in bits 7 to 0.
    function automatic logic [7:0] delim_byte(input logic [63:0] pat, input int unsigned k);
        return pat[8 * (k % PATTERN_BYTES) +: 8];
    endfunction

    // A delimiter length of zero behaves as one, anything above eight as eight.
    function automatic int unsigned usable_len(input logic [3:0] len);
        if (len == 4'd0) begin
            return 1;
        end
        if (len > PATTERN_BYTES) begin
            return PATTERN_BYTES;
        end
        return len;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Advances the state copy by one accepted input transaction and queues the results
    // that it causes.
    task automatic extract_step(input logic [1:0] op, input logic [7:0] b);
        int unsigned lim;
        int unsigned slen;
        int unsigned elen;
        frame_out_t  r;
        lim  = (cfg_ml > MAX_LIMIT) ? MAX_LIMIT : cfg_ml;
        slen = usable_len(cfg_sl);
        elen = usable_len(cfg_el);

        // A restart clears the search even after a finished frame; the store is kept.
        if (op == OP_RESTART) begin
            fill_idx   = 0;
            hdr_found  = 1'b0;
            tail_hits  = 0;
            tick_acc   = 32'd0;
            frame_done = 1'b0;
            return;
        end
        // The unused code and anything arriving after a frame or a timeout is dropped.
        if (op == OP_UNUSED || frame_done) begin
            return;
        end

        if (op == OP_TICK) begin
            if (tick_acc != 32'hFFFF_FFFF) begin
                tick_acc++;
            end
            if (tick_acc >= cfg_tmo) begin
                frame_done = 1'b1;
                r = '{kind: KIND_TIMEOUT, fbyte: 8'h00, pos: 6'd0, is_last: 1'b1};
                out_due.push_back(r);
            end
            return;
        end

        if (!hdr_found) begin
            // Naive restart: a mismatch drops the partial start delimiter, unless the
            // byte itself opens the delimiter again.
            if (b == delim_byte(cfg_sp, fill_idx)) begin
                store_img[fill_idx % MAX_FRAME] = b;
                fill_idx++;
                if (fill_idx >= slen) begin
                    hdr_found = 1'b1;
                    fill_idx--;
                end
            end else if (b == delim_byte(cfg_sp, 0)) begin
                store_img[0] = b;
                fill_idx     = 1;
            end else begin
                fill_idx = 0;
            end
        end else begin
            fill_idx++;
            store_img[fill_idx % MAX_FRAME] = b;
            if (b == delim_byte(cfg_ep, tail_hits)) begin
                tail_hits++;
                // A count already at or past a lowered length completes here too.
                if (tail_hits >= elen) begin
                    frame_done = 1'b1;
                    for (int i = 0; i <= fill_idx; i++) begin
                        r.kind    = KIND_BYTE;
                        r.fbyte   = store_img[i % MAX_FRAME];
                        r.pos     = 6'(i);
                        r.is_last = (i == fill_idx);
                        out_due.push_back(r);
                    end
                    // The completing byte is exempt from the length limit.
                    return;
                end
            end else if (b == delim_byte(cfg_ep, 0)) begin
                tail_hits = 1;
            end else begin
                tail_hits = 0;
            end
        end

        // A frame that grows past the limit is abandoned and the hunt starts over.
        if (fill_idx > lim) begin
            fill_idx  = 0;
            hdr_found = 1'b0;
            tail_hits = 0;
        end
    endtask

    // Sender. It offers transactions in bursts of random length separated by random
    // gaps, including long bursts with no gap at all. Once valid is up it holds the
    // payload until the transaction is accepted.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        rx_item_t it;
        int       pick;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                extract_step(s_op, s_data_byte);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (rx_stream.size() > 0) begin
                    it          = rx_stream.pop_front();
                    s_valid     <= 1'b1;
                    s_op        <= it.op;
                    s_data_byte <= it.data;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        pick       = $urandom_range(0, 9);
                        if (pick < 3) begin
                            gap_left = 0;
                        end else if (pick < 8) begin
                            gap_left = $urandom_range(1, 3);
                        end else begin
                            gap_left = $urandom_range(4, 20);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every so often it picks a new way of stalling: always ready, a coin
    // flip, mostly stalled, or a repeating mask of eight bits.
    int         sink_mode  = 0;
    int         mode_timer = 0;
    int         sink_phase = 0;
    logic [7:0] sink_mask  = 8'hFF;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_timer == 0) begin
                sink_mode  = $urandom_range(0, 3);
                mode_timer = $urandom_range(20, 120);
                sink_mask  = 8'($urandom) | 8'h01;
            end else begin
                mode_timer--;
            end
            sink_phase = (sink_phase + 1) % 8;
            case (sink_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    m_ready <= sink_mask[sink_phase];
                end
            endcase
        end
    end

    // Monitor. Each accepted result transaction must match the oldest one still due.
    always @(posedge aclk) begin
        frame_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (m_kind === KIND_TIMEOUT) begin
                timeouts_seen++;
            end else if (m_last === 1'b1) begin
                frames_seen++;
            end
            if (out_due.size() == 0) begin
                flag_error($sformatf("result with nothing due: kind %0d byte %02h index %0d last %0d",
                                     m_kind, m_frame_byte, m_byte_index, m_last));
            end else begin
                want = out_due.pop_front();
                if (m_kind !== want.kind) begin
                    flag_error($sformatf("kind %0d, expected %0d", m_kind, want.kind));
                end
                if (m_frame_byte !== want.fbyte) begin
                    flag_error($sformatf("frame byte %02h, expected %02h at index %0d",
                                         m_frame_byte, want.fbyte, want.pos));
                end
                if (m_byte_index !== want.pos) begin
                    flag_error($sformatf("byte index %0d, expected %0d",
                                         m_byte_index, want.pos));
                end
                if (m_last !== want.is_last) begin
                    flag_error($sformatf("last %0d, expected %0d at index %0d",
                                         m_last, want.is_last, want.pos));
                end
            end
        end
    end

    // Watchdog. Any accepted transaction on either side restarts the count.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction, %0d results still due",
                     quiet_cycles, out_due.size());
            $display("tb_delimited_frame_extractor: errors");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [7:0] b);
        rx_item_t it;
        it.op   = op;
        it.data = b;
        rx_stream.push_back(it);
        if (op != OP_UNUSED) begin
            stim_count++;
        end
    endtask

    // Waits until everything queued has been taken and every result due has arrived,
    // then lets the pipeline settle. Polling on the falling edge keeps
    // it clear of the driver's updates at the rising edge.
    task automatic wait_idle();
        @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || out_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    // Writes all six registers back to back on consecutive edges, and the same values
    // into the behavioral copy. Only called while the block is idle.
    task automatic load_config(input logic [63:0] sp, input logic [3:0] sl,
                               input logic [63:0] ep, input logic [3:0] el,
                               input logic [5:0] ml, input logic [31:0] tmo);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_PATTERN;
        cfg_wdata <= sp;
        @(posedge aclk);
        cfg_index <= REG_START_LENGTH;
        cfg_wdata <= 64'(sl);
        @(posedge aclk);
        cfg_index <= REG_END_PATTERN;
        cfg_wdata <= ep;
        @(posedge aclk);
        cfg_index <= REG_END_LENGTH;
        cfg_wdata <= 64'(el);
        @(posedge aclk);
        cfg_index <= REG_MAX_LENGTH;
        cfg_wdata <= 64'(ml);
        @(posedge aclk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_wdata <= 64'(tmo);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_sp  = sp;
        cfg_sl  = sl;
        cfg_ep  = ep;
        cfg_el  = el;
        cfg_ml  = ml;
        cfg_tmo = tmo;
        settings_loaded++;
    endtask

    // One random sequence. Most are well-formed frames with random bodies; the rest are tick
    // runs, broken delimiters, unused codes and frames that are cut off by a restart.
    task automatic gen_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned slen;
        int unsigned elen;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        slen = usable_len(cfg_sl);
        elen = usable_len(cfg_el);
        lead = delim_byte(cfg_sp, 0);
        if (pick < 60) begin
            // Leading noise, often a stray copy of the first start byte.
            repeat ($urandom_range(0, 2)) begin
                push_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? lead : 8'($urandom));
            end
            for (int k = 0; k < slen; k++) begin
                push_item(OP_BYTE, delim_byte(cfg_sp, k));
            end
            // Mostly short bodies; now and then one long enough to hit the limit.
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_item(OP_TICK, 8'($urandom));
                end
                push_item(OP_BYTE, 8'($urandom));
            end
            for (int k = 0; k < elen; k++) begin
                push_item(OP_BYTE, delim_byte(cfg_ep, k));
            end
            // Without a restart, what follows lands on a finished search.
            if ($urandom_range(0, 9) != 0) begin
                push_item(OP_RESTART, 8'($urandom));
            end
        end else if (pick < 72) begin
            repeat ($urandom_range(1, 6)) begin
                push_item(OP_TICK, 8'($urandom));
            end
            push_item(OP_RESTART, 8'($urandom));
        end else if (pick < 86) begin
            n = $urandom_range(0, slen);
            for (int k = 0; k < n; k++) begin
                push_item(OP_BYTE, delim_byte(cfg_sp, k));
            end
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 2))
                    0: push_item(OP_BYTE, lead);
                    1: push_item(OP_BYTE, delim_byte(cfg_ep, $urandom_range(0, 7)));
                    default: push_item(OP_BYTE, 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                push_item(OP_RESTART, 8'($urandom));
            end
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 3)) begin
                push_item(OP_UNUSED, 8'($urandom));
            end
        end else begin
            for (int k = 0; k < slen; k++) begin
                push_item(OP_BYTE, delim_byte(cfg_sp, k));
            end
            n = $urandom_range(0, elen - 1);
            for (int k = 0; k < n; k++) begin
                push_item(OP_BYTE, delim_byte(cfg_ep, k));
            end
            push_item(OP_RESTART, 8'($urandom));
        end
    endtask

    initial begin
        int phase_goal;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: one zero byte opens a frame and one zero byte closes it. The
        // bytes and the tick after completion are dropped, then the unused code and a
        // restart follow.
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h5A);
        push_item(OP_TICK, 8'hFF);
        push_item(OP_UNUSED, 8'hAA);
        push_item(OP_RESTART, 8'h00);
        wait_idle();

        // A start length of zero acts as one and an end length above eight as eight.
        // The limit is above the clamp of 62, and a zero timeout fires on the first tick.
        load_config({$urandom, 24'h123456, 8'hA5}, 4'd0, 64'h8877_6655_4433_2211,
                    4'd12, 6'd63, 32'd0);
        push_item(OP_TICK, 8'h00);
        push_item(OP_RESTART, 8'h00);
        push_item(OP_BYTE, 8'hA5);
        for (int k = 0; k < 8; k++) begin
            push_item(OP_BYTE, 8'(8'h11 * (k + 1)));
        end
        push_item(OP_RESTART, 8'h00);
        wait_idle();

        // A tiny limit abandons a frame on its fifth byte. The next frame stops two
        // bytes into its end delimiter; the end length then drops to one, so the next
        // matching byte completes it even though it lands past the limit.
        load_config(64'h0000_0000_0000_C33C, 4'd2, 64'h0000_0000_0033_2211, 4'd3,
                    6'd3, 32'hFFFF_FFFF);
        push_item(OP_BYTE, 8'h3C);
        push_item(OP_BYTE, 8'hC3);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, 8'h3C);
        push_item(OP_BYTE, 8'hC3);
        push_item(OP_BYTE, 8'h11);
        push_item(OP_BYTE, 8'h22);
        wait_idle();
        load_config(cfg_sp, cfg_sl, cfg_ep, 4'd1, cfg_ml, cfg_tmo);
        push_item(OP_BYTE, 8'h33);
        push_item(OP_RESTART, 8'h00);
        wait_idle();

        // Random part: six register settings, each followed by random sequences. The
        // search state is not cleared between settings, so partial matches run into
        // changed lengths and limits.
        phase_goal = stim_count;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_config({$urandom, $urandom}, 4'd2, {$urandom, $urandom}, 4'd2,
                               6'd62, 32'd4);
                1: load_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'd0, 4'd8,
                               6'd63, 32'hFFFF_FFFF);
                2: load_config({$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd1,
                               6'd0, 32'd0);
                3: load_config({$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 4'd0,
                               6'($urandom_range(8, 20)), 32'd10);
                4: load_config({$urandom, $urandom}, 4'($urandom_range(1, 4)),
                               {$urandom, $urandom}, 4'($urandom_range(1, 4)),
                               6'($urandom_range(0, 63)), 32'($urandom_range(1, 8)));
                default: load_config({$urandom, $urandom}, 4'($urandom_range(1, 8)),
                                     {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                                     6'd62, RST_TIMEOUT);
            endcase
            phase_goal += 18;
            while (stim_count < phase_goal) begin
                gen_sequence();
                // Now and then the sender holds back until every result is in.
                if ($urandom_range(0, 7) == 0) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        $display("covered %0d input and %0d result transactions over %0d register settings,",
                 items_taken, results_seen, settings_loaded + 1);
        $display("with %0d complete frames and %0d timeout reports", frames_seen,
                 timeouts_seen);
        if (err_count == 0) begin
            $display("tb_delimited_frame_extractor: clean");
        end else begin
            $display("tb_delimited_frame_extractor: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/dfe_pkg.sv
design/dfe_front.sv
design/dfe_queue.sv
design/dfe_back.sv
design/delimited_frame_extractor.sv
design/dfe_checker.sv
tb/tb_delimited_frame_extractor.sv
